// ===== sv/c2d_pkg.sv =====
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and codes for the 5x5 six-channel convolution core
// Request codes, sequencer states and the MAC control group.
// ----------------------------------------------------------------------------
`default_nettype none
package c2d_pkg;

    localparam int DATA_W  = 16;   // pixel and weight width
    localparam int VALUE_W = 32;   // bias and result width
    localparam int RND_SH  = 14;   // Q.22 -> Q.8
    localparam int RND_ADD = 8192; // half LSB at Q.8

    localparam logic [1:0] REQ_PIXEL  = 2'd0;
    localparam logic [1:0] REQ_WEIGHT = 2'd1;
    localparam logic [1:0] REQ_BIAS   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINE,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_BIAS,
        S_ROUND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;    // zero the accumulator
        logic mul_en;   // operands valid this cycle
        logic add_bias; // add the bias word into the accumulator
    } t_mac_ctl;

endpackage
`default_nettype wire

// ===== sv/c2d_if.sv =====
// ----------------------------------------------------------------------------
// c2d_if: request and result channels of the convolution core
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none
interface c2d_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic               start_of_image;
    logic signed [15:0] pixel;
    logic [7:0]         coef_index;
    logic signed [31:0] coef_value;

    modport source (output valid, req_type, start_of_image, pixel, coef_index,
                    coef_value, input ready);
    modport sink   (input valid, req_type, start_of_image, pixel, coef_index,
                    coef_value, output ready);
endinterface

interface c2d_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic [2:0]         out_channel;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic               last;
    logic               image_done;

    modport source (output valid, out_value, out_channel, out_row, out_col, last,
                    image_done, input ready);
    modport sink   (input valid, out_value, out_channel, out_row, out_col, last,
                    image_done, output ready);
endinterface
`default_nettype wire

// ===== sv/c2d_ram.sv =====
// ----------------------------------------------------------------------------
// c2d_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/c2d_mac.sv =====
// ----------------------------------------------------------------------------
// c2d_mac: shared multiply-accumulate unit
// Registered 16x16 product, then accumulate; bias add on request.
// ----------------------------------------------------------------------------
`default_nettype none
module c2d_mac
    import c2d_pkg::*;
#(
    parameter int ACC_W = 40
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_mac_ctl                  i_ctl,
    input  wire logic signed [DATA_W-1:0]  i_a,
    input  wire logic signed [DATA_W-1:0]  i_b,
    input  wire logic signed [VALUE_W-1:0] i_bias,
    output logic                           o_busy,
    output logic signed [ACC_W-1:0]        o_acc
);
    logic signed [2*DATA_W-1:0] r_prod;
    logic                       r_pv;
    logic signed [ACC_W-1:0]    r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.add_bias) begin
            r_acc <= r_acc + ACC_W'(i_bias);
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_busy = r_pv;
    assign o_acc  = r_acc;
endmodule
`default_nettype wire

// ===== sv/conv2d_5x5_six_channel_core.sv =====
// ----------------------------------------------------------------------------
// conv2d_5x5_six_channel_core: valid KxK convolution, one in, many maps out
// A load item is taken in S_IDLE; a pixel passes S_LINE and, if it closes a
// window, then runs S_MAC, S_DRAIN1, S_DRAIN2, S_BIAS, S_ROUND and S_OUT for
// each of the OUT_CHANNELS maps, waiting in S_OUT for a ready sink. No request
// is taken meanwhile; the single shared multiplier steps through 25 taps per map.
// Reset: synchronous active low; clears row/col counters and the sequencer.
// Line, window, weight and bias stores are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module conv2d_5x5_six_channel_core
    import c2d_pkg::*;
#(
    parameter int IMG_SIZE     = 28,
    parameter int KERNEL_SIZE  = 5,
    parameter int OUT_CHANNELS = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    c2d_req_if.sink   i_req,
    c2d_res_if.source o_res
);
    // ---- derived sizes ----
    localparam int KK     = KERNEL_SIZE * KERNEL_SIZE;
    localparam int WC     = OUT_CHANNELS * KK;
    localparam int LROWS  = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
    localparam int LW     = DATA_W * LROWS;
    localparam int RC_W   = $clog2(IMG_SIZE);
    localparam int LA_W   = (IMG_SIZE > 1) ? $clog2(IMG_SIZE) : 1;
    localparam int WA_W   = (WC > 1) ? $clog2(WC) : 1;
    localparam int KI_W   = (KK > 1) ? $clog2(KK) : 1;
    localparam int CH_W   = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int ACC_W  = 2 * DATA_W + $clog2(KK) + 2;

    // ---- state ----
    t_state r_state, n_state;

    logic [RC_W-1:0] r_prow, r_pcol;   // position of the next pixel
    logic [RC_W-1:0] r_crow, r_ccol;   // position of the pixel at work
    logic signed [DATA_W-1:0] r_px;
    logic [4:0]      r_orow, r_ocol;   // output map position tags
    logic            r_end;            // this pixel closes the image
    logic            r_full;

    logic signed [DATA_W-1:0]  r_win [KK];
    logic signed [VALUE_W-1:0] r_bias [OUT_CHANNELS];

    logic [KI_W-1:0] r_kidx;           // tap within the window
    logic [WA_W-1:0] r_widx;           // running weight address
    logic [CH_W-1:0] r_ch;
    logic            r_v1;             // weight read in flight
    logic signed [DATA_W-1:0] r_wv;    // window tap aligned with weight data

    logic signed [VALUE_W-1:0] r_out_value;

    // ---- handshakes ----
    logic acc_in, acc_out, is_pixel;
    assign acc_in   = i_req.valid && i_req.ready;
    assign acc_out  = o_res.valid && o_res.ready;
    assign is_pixel = i_req.req_type == REQ_PIXEL;

    // ---- line buffer: one word per column holds the last K-1 rows ----
    logic [LW-1:0]   line_rdata, line_wdata;
    logic [LA_W-1:0] line_raddr;
    assign line_raddr = (i_req.start_of_image) ? '0 : LA_W'(r_pcol);

    c2d_ram #(.WIDTH(LW), .DEPTH(IMG_SIZE)) u_line (
        .i_clk   (i_clk),
        .i_we    (r_state == S_LINE),
        .i_waddr (LA_W'(r_ccol)),
        .i_wdata (line_wdata),
        .i_re    (acc_in && is_pixel),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    // rows move up one; the new pixel enters the bottom row
    genvar g;
    generate
        for (g = 0; g < LROWS; g++) begin : g_lrow
            if (g < LROWS - 1) begin : g_up
                assign line_wdata[g*DATA_W +: DATA_W] = line_rdata[(g+1)*DATA_W +: DATA_W];
            end else begin : g_new
                assign line_wdata[g*DATA_W +: DATA_W] = r_px;
            end
        end
    endgenerate

    // ---- weight store ----
    logic                     w_we;
    logic [DATA_W-1:0]        w_rdata;
    assign w_we = acc_in && (i_req.req_type == REQ_WEIGHT)
                  && (32'(i_req.coef_index) < 32'(WC));

    c2d_ram #(.WIDTH(DATA_W), .DEPTH(WC)) u_weight (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (WA_W'(i_req.coef_index)),
        .i_wdata (i_req.coef_value[DATA_W-1:0]),
        .i_re    (r_state == S_MAC),
        .i_raddr (r_widx),
        .o_rdata (w_rdata)
    );

    // ---- shared MAC ----
    t_mac_ctl                 mac_ctl;
    logic                     mac_busy;
    logic signed [ACC_W-1:0]  mac_acc;

    c2d_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (r_wv),
        .i_b     ($signed(w_rdata)),
        .i_bias  (r_bias[r_ch]),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    function automatic logic r_full_now();
        r_full_now = (32'(r_crow) >= 32'(KERNEL_SIZE - 1))
                     && (32'(r_ccol) >= 32'(KERNEL_SIZE - 1));
    endfunction

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in && is_pixel) n_state = S_LINE;
            end
            S_LINE: begin
                n_state = (r_full_now()) ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                if (r_kidx == KI_W'(KK - 1)) n_state = S_DRAIN1;
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_BIAS;
            S_BIAS:   n_state = S_ROUND;
            S_ROUND:  n_state = S_OUT;
            S_OUT: begin
                if (acc_out) begin
                    n_state = (r_ch == CH_W'(OUT_CHANNELS - 1)) ? S_IDLE : S_MAC;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // ---- outputs of the sequencer ----
    always_comb begin
        i_req.ready      = 1'b0;
        o_res.valid      = 1'b0;
        mac_ctl.clear    = 1'b0;
        mac_ctl.mul_en   = r_v1;
        mac_ctl.add_bias = 1'b0;
        unique case (r_state)
            S_IDLE:  i_req.ready      = 1'b1;
            S_LINE:  mac_ctl.clear    = 1'b1;
            S_BIAS:  mac_ctl.add_bias = 1'b1;
            S_ROUND: mac_ctl.clear    = 1'b1;
            S_OUT:   o_res.valid      = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prow  <= '0;
            r_pcol  <= '0;
            r_v1    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_MAC);
            if (r_state == S_LINE) begin
                // advance raster position, wrapping at the image end
                if (r_ccol == RC_W'(IMG_SIZE - 1)) begin
                    r_pcol <= '0;
                    r_prow <= (r_crow == RC_W'(IMG_SIZE - 1)) ? '0 : r_crow + 1'b1;
                end else begin
                    r_pcol <= r_ccol + 1'b1;
                    r_prow <= r_crow;
                end
            end
        end
    end

    // ---- datapath registers ----
    logic signed [ACC_W-1:0] rnd_sum, rnd_sh;
    localparam logic signed [ACC_W-1:0] SAT_HI = $signed({{(ACC_W-32){1'b0}}, 32'h7fffffff});
    localparam logic signed [ACC_W-1:0] SAT_LO = $signed({{(ACC_W-32){1'b1}}, 32'h80000000});
    assign rnd_sum = mac_acc + ACC_W'(RND_ADD);
    assign rnd_sh  = rnd_sum >>> RND_SH;

    always_ff @(posedge i_clk) begin
        // pixel capture and load items
        if (acc_in && is_pixel) begin
            r_px   <= i_req.pixel;
            r_ccol <= i_req.start_of_image ? '0 : r_pcol;
            r_crow <= i_req.start_of_image ? '0 : r_prow;
        end
        if (acc_in && (i_req.req_type == REQ_BIAS)
            && (32'(i_req.coef_index) < 32'(OUT_CHANNELS))) begin
            r_bias[CH_W'(i_req.coef_index)] <= i_req.coef_value;
        end

        // window shift as the line word arrives
        if (r_state == S_LINE) begin
            for (int kh = 0; kh < KERNEL_SIZE; kh++) begin
                for (int kw = 0; kw < KERNEL_SIZE - 1; kw++) begin
                    r_win[kh*KERNEL_SIZE + kw] <= r_win[kh*KERNEL_SIZE + kw + 1];
                end
                if (kh < KERNEL_SIZE - 1) begin
                    r_win[kh*KERNEL_SIZE + KERNEL_SIZE - 1] <=
                        $signed(line_rdata[(kh % LROWS)*DATA_W +: DATA_W]);
                end else begin
                    r_win[kh*KERNEL_SIZE + KERNEL_SIZE - 1] <= r_px;
                end
            end
            r_full <= r_full_now();
            r_end  <= (r_crow == RC_W'(IMG_SIZE - 1)) && (r_ccol == RC_W'(IMG_SIZE - 1));
            r_orow <= 5'(r_crow - RC_W'(KERNEL_SIZE - 1));
            r_ocol <= 5'(r_ccol - RC_W'(KERNEL_SIZE - 1));
            r_kidx <= '0;
            r_widx <= '0;
            r_ch   <= '0;
        end

        // tap walk: window tap registered alongside the weight read
        if (r_state == S_MAC) begin
            r_wv   <= r_win[r_kidx];
            r_widx <= (r_widx == WA_W'(WC - 1)) ? '0 : r_widx + 1'b1;
            r_kidx <= (r_kidx == KI_W'(KK - 1)) ? '0 : r_kidx + 1'b1;
        end

        // round half up at Q.8 and saturate to 32 bits
        if (r_state == S_ROUND) begin
            if (rnd_sh > SAT_HI) begin
                r_out_value <= 32'sh7fffffff;
            end else if (rnd_sh < SAT_LO) begin
                r_out_value <= 32'sh80000000;
            end else begin
                r_out_value <= rnd_sh[31:0];
            end
        end

        if (acc_out && (r_ch != CH_W'(OUT_CHANNELS - 1))) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    // ---- result item ----
    assign o_res.out_value   = r_out_value;
    assign o_res.out_channel = 3'(r_ch);
    assign o_res.out_row     = r_orow;
    assign o_res.out_col     = r_ocol;
    assign o_res.last        = (r_ch == CH_W'(OUT_CHANNELS - 1));
    assign o_res.image_done  = r_end && (r_ch == CH_W'(OUT_CHANNELS - 1));

`ifndef NO_ASSERTIONS
    // input and output sides never both open: one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_res.valid))
        else $error("request taken while a result is pending");

    // the MAC pipe has drained before the bias is added
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIAS) |-> (!r_v1 && !mac_busy))
        else $error("bias added with products in flight");

    // results only for pixels that closed a window
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> r_full)
        else $error("result for an incomplete window");

    // a new channel pass always starts at tap zero
    a_tap0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_out && !o_res.last) |=> (r_state == S_MAC && r_kidx == '0))
        else $error("channel pass did not restart at tap zero");
`endif

endmodule
`default_nettype wire

// ===== test/tb_conv_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conv_pkg: item types shared by the convolution testbench
// Holds the request item layout used by the stimulus queue and the driver, and the result item layout.
// ----------------------------------------------------------------------------
package tb_conv_pkg;
    import c2d_pkg::*;

    typedef struct {
        logic [1:0]         req_type;
        logic               start_of_image;
        logic signed [15:0] pixel;
        logic [7:0]         coef_index;
        logic signed [31:0] coef_value;
    } t_req_item;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         channel;
        logic [4:0]         row;
        logic [4:0]         col;
        logic               last;
        logic               image_done;
    } t_res_item;
endpackage

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 5x5 six-channel convolution core
// Loads coefficients, streams pixels with random gaps and output stalls,
// and checks every result item against an in-bench conv predictor.
// ----------------------------------------------------------------------------
module tb;
    import c2d_pkg::*;
    import tb_conv_pkg::*;

    localparam int IMG    = 28;
    localparam int KS     = 5;
    localparam int NCH    = 6;
    localparam int NTAP   = KS * KS;
    localparam int NW     = NCH * NTAP;
    localparam int OUT_SZ = IMG - KS + 1;
    localparam logic [1:0] REQ_NONE = 2'd3; // unused code, block ignores it
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    c2d_req_if req_ch ();
    c2d_res_if res_ch ();

    conv2d_5x5_six_channel_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- predictor state ----------------
    logic signed [15:0] lines_q [KS-1][IMG];
    logic signed [15:0] win_q   [KS][KS];
    logic signed [15:0] wts_q   [NW];
    logic signed [31:0] bias_q  [NCH];
    int unsigned        prow, pcol;

    t_req_item pending_reqs[$];  // stimulus waiting for the driver
    t_res_item conv_expect[$];   // predicted results, oldest first
    int        n_fail = 0;
    longint    cycle_cnt = 0;
    bit        stim_done = 1'b0;
    bit        drv_done  = 1'b0;

    // Q.22 sum -> Q.8, round half up by floor, saturate to 32 bits
    function automatic logic signed [31:0] q8_round_sat(longint acc);
        longint r;
        r = (acc + RND_ADD) >>> RND_SH;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // apply one accepted request to the predictor, queue its results
    task automatic conv_predict(input t_req_item it);
        longint    acc;
        t_res_item r;
        logic signed [15:0] px;
        if (it.req_type == REQ_WEIGHT) begin
            if (it.coef_index < NW) wts_q[it.coef_index] = it.coef_value[15:0];
        end else if (it.req_type == REQ_BIAS) begin
            if (it.coef_index < NCH) bias_q[it.coef_index] = it.coef_value;
        end else if (it.req_type == REQ_PIXEL) begin
            if (it.start_of_image) begin
                prow = 0;
                pcol = 0;
            end
            px = it.pixel;
            // window slides left; new column from line store plus new pixel
            for (int kh = 0; kh < KS; kh++) begin
                for (int kw = 0; kw < KS - 1; kw++) win_q[kh][kw] = win_q[kh][kw+1];
                win_q[kh][KS-1] = (kh < KS - 1) ? lines_q[kh][pcol] : px;
            end
            for (int kh = 0; kh < KS - 2; kh++) lines_q[kh][pcol] = lines_q[kh+1][pcol];
            lines_q[KS-2][pcol] = px;
            if (prow >= KS - 1 && pcol >= KS - 1) begin
                for (int ch = 0; ch < NCH; ch++) begin
                    acc = 0;
                    for (int kh = 0; kh < KS; kh++)
                        for (int kw = 0; kw < KS; kw++)
                            acc += longint'(win_q[kh][kw]) *
                                   longint'(wts_q[ch*NTAP + kh*KS + kw]);
                    acc += longint'(bias_q[ch]);
                    r.value      = q8_round_sat(acc);
                    r.channel    = 3'(ch);
                    r.row        = 5'(prow - (KS - 1));
                    r.col        = 5'(pcol - (KS - 1));
                    r.last       = (ch == NCH - 1);
                    r.image_done = (ch == NCH - 1) && prow == IMG - 1 && pcol == IMG - 1;
                    conv_expect.push_back(r);
                end
            end
            pcol++;
            if (pcol >= IMG) begin
                pcol = 0;
                prow++;
                if (prow >= IMG) prow = 0;
            end
        end
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic t_req_item mk_item(logic [1:0] t, logic sof, logic [15:0] px,
                                          logic [7:0] idx, logic [31:0] val);
        t_req_item it;
        it.req_type = t; it.start_of_image = sof; it.pixel = px;
        it.coef_index = idx; it.coef_value = val;
        return it;
    endfunction

    // random 32-bit word, biased toward the field extremes now and then
    function automatic logic [31:0] rnd_word(int wbits);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 32'h8000_0000 >> (32 - wbits);
        if (sel == 1) return 32'hFFFF_FFFF >> (32 - wbits + 1);
        return $urandom;
    endfunction

    task automatic load_coefs(int mode);
        // mode 0 random, 1 max, 2 min, 3 small random
        logic [31:0] v;
        for (int i = 0; i < NW; i++) begin
            case (mode)
                1: v = 32'h0000_7FFF | ($urandom & 32'hFFFF_0000);
                2: v = 32'h0000_8000 | ($urandom & 32'hFFFF_0000);
                3: v = $urandom_range(0, 255) - 128;
                default: v = $urandom;
            endcase
            pending_reqs.push_back(mk_item(REQ_WEIGHT, 1'($urandom), 16'($urandom),
                                           8'(i), v));
        end
        for (int i = 0; i < NCH; i++) begin
            case (mode)
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h8000_0000;
                3: v = $urandom_range(0, 65535) - 32768;
                default: v = $urandom;
            endcase
            pending_reqs.push_back(mk_item(REQ_BIAS, 1'($urandom), 16'($urandom),
                                           8'(i), v));
        end
    endtask

    // a run of pixels; mode picks the pixel pattern
    task automatic push_image(int mode, bit sof, int count);
        logic [15:0] px;
        for (int i = 0; i < count; i++) begin
            case (mode)
                1: px = 16'h7FFF;
                2: px = 16'h8000;
                3: px = (i % 2) ? 16'h7FFF : 16'h8000;
                default: px = 16'(rnd_word(16));
            endcase
            pending_reqs.push_back(mk_item(REQ_PIXEL, sof && i == 0, px,
                                           8'($urandom), $urandom));
        end
    endtask

    // ---------------- driver ----------------
    int        gap_cnt = 0;
    t_req_item cur;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_ch.ready) begin
            // hold the item until taken
        end else begin
            if (req_ch.valid) conv_predict(cur);
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur = pending_reqs.pop_front();
                req_ch.valid          <= 1'b1;
                req_ch.req_type       <= cur.req_type;
                req_ch.start_of_image <= cur.start_of_image;
                req_ch.pixel          <= cur.pixel;
                req_ch.coef_index     <= cur.coef_index;
                req_ch.coef_value     <= cur.coef_value;
                // gap before the next item, with long runs of no gap
                gap_cnt <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            end else begin
                req_ch.valid <= 1'b0;
                if (stim_done) drv_done <= 1'b1;
            end
        end
    end

    // ---------------- monitor ----------------
    int        stall_cnt = 0;
    t_res_item want;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (conv_expect.size() == 0) begin
                    $error("unexpected result ch=%0d row=%0d col=%0d",
                           res_ch.out_channel, res_ch.out_row, res_ch.out_col);
                    n_fail++;
                end else begin
                    want = conv_expect.pop_front();
                    if (res_ch.out_value !== want.value) begin
                        $error("out_value exp %0d got %0d", want.value, res_ch.out_value);
                        n_fail++;
                    end
                    if (res_ch.out_channel !== want.channel) begin
                        $error("out_channel exp %0d got %0d", want.channel,
                               res_ch.out_channel);
                        n_fail++;
                    end
                    if (res_ch.out_row !== want.row) begin
                        $error("out_row exp %0d got %0d", want.row, res_ch.out_row);
                        n_fail++;
                    end
                    if (res_ch.out_col !== want.col) begin
                        $error("out_col exp %0d got %0d", want.col, res_ch.out_col);
                        n_fail++;
                    end
                    if (res_ch.last !== want.last) begin
                        $error("last exp %0b got %0b", want.last, res_ch.last);
                        n_fail++;
                    end
                    if (res_ch.image_done !== want.image_done) begin
                        $error("image_done exp %0b got %0b", want.image_done,
                               res_ch.image_done);
                        n_fail++;
                    end
                end
            end
            // stall draw per result; some stretches always ready
            if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (res_ch.valid && res_ch.ready && $urandom_range(0, 3) == 0)
                    stall_cnt <= $urandom_range(0, 16);
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PIXEL;
        req_ch.start_of_image = 1'b0;
        req_ch.pixel = '0;
        req_ch.coef_index = '0;
        req_ch.coef_value = '0;
        res_ch.ready = 1'b0;
        prow = 0;
        pcol = 0;
        // the block's stores start undefined; the predictor is only read after loads
        foreach (lines_q[a, b]) lines_q[a][b] = '0;
        foreach (win_q[a, b]) win_q[a][b] = '0;
        foreach (wts_q[a]) wts_q[a] = '0;
        foreach (bias_q[a]) bias_q[a] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random coefficients, then ignored codes and out-of-range loads
        load_coefs(0);
        pending_reqs.push_back(mk_item(REQ_WEIGHT, 1'b1, 16'h7FFF, 8'd150, 32'h1234));
        pending_reqs.push_back(mk_item(REQ_WEIGHT, 1'b0, 16'h8000, 8'd255, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_item(REQ_BIAS, 1'b1, 16'h0, 8'd6, 32'h5555_5555));
        pending_reqs.push_back(mk_item(REQ_BIAS, 1'b0, 16'hFFFF, 8'd255, 32'hAAAA_AAAA));
        pending_reqs.push_back(mk_item(REQ_NONE, 1'b1, 16'h7FFF, 8'd0, 32'h7FFF_FFFF));
        pending_reqs.push_back(mk_item(REQ_NONE, 1'b0, 16'h8000, 8'd255, 32'h8000_0000));
        // rows 0..3 fill the line store; row 4 closes the first windows
        push_image(0, 1'b1, (KS - 1) * IMG + KS + 1);
        // bias reload between pixels, then alternating extremes on the same row
        for (int i = 0; i < NCH; i++)
            pending_reqs.push_back(mk_item(REQ_BIAS, 1'($urandom), 16'($urandom),
                                           8'(i), $urandom));
        push_image(3, 1'b0, 8);
        // noise: ignored codes and stray loads
        for (int i = 0; i < 6; i++)
            pending_reqs.push_back(mk_item($urandom_range(0, 1) ? REQ_NONE : REQ_BIAS,
                                           1'($urandom), 16'($urandom),
                                           8'($urandom_range(6, 255)), $urandom));
        stim_done = 1'b1;
    end

    // ---------------- end of run ----------------
    initial begin
        wait (drv_done);
        wait (conv_expect.size() == 0);
        repeat (400) @(posedge i_clk);
        if (n_fail == 0 && conv_expect.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb NOT OK");
        $finish;
    end
endmodule
